### hdl/rnp_pkg.sv
// Shared types and constants for the ASCII radix number parser.
package rnp_pkg;

   // Parse phase within one token
   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_BASE   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   // Radix selected by the base letter
   typedef enum logic [1:0] {
      RK_DEC = 2'd0,
      RK_BIN = 2'd1,
      RK_OCT = 2'd2,
      RK_HEX = 2'd3
   } radix_type;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_BASE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_DIGIT = 2'd2;

   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int STATUS_W = 2;
   localparam int RESULT_W = 64;
   localparam int RSP_DATA_W = ((RESULT_W + STATUS_W + 7) / 8) * 8;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UC_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_F   = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_F   = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LC_D   = 8'h64;
   localparam logic [CHAR_W-1:0] CHAR_LC_B   = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_LC_O   = 8'h6F;
   localparam logic [CHAR_W-1:0] CHAR_LC_X   = 8'h78;

   // Letter digits a..f map to low nibble plus nine
   localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 4'd9;
   localparam logic [DIGIT_W-1:0] DEC_LIMIT     = 4'd10;
   localparam logic [DIGIT_W-1:0] OCT_LIMIT     = 4'd8;
   localparam logic [DIGIT_W-1:0] BIN_LIMIT     = 4'd2;

   // Classification of one character
   typedef struct packed {
      logic                is_minus;
      logic                base_ok;
      radix_type           base_kind;
      logic                digit_ok;
      logic [DIGIT_W-1:0]  digit;
   } decode_type;

endpackage

### hdl/rnp_char_decode.sv
// Character classifier: sign, base letter and digit value for the current radix.
module rnp_char_decode
   import rnp_pkg::*;
(
   input  logic [CHAR_W-1:0] char_code,
   input  radix_type         radix,
   output decode_type        dec
);

   logic               is_num;
   logic               is_letter;
   logic [DIGIT_W-1:0] raw_digit;

   // Find raw digit value over 0-9, a-f, A-F
   always_comb begin
      is_num    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_letter = ((char_code >= CHAR_LC_A) && (char_code <= CHAR_LC_F)) ||
                  ((char_code >= CHAR_UC_A) && (char_code <= CHAR_UC_F));
      if (is_letter) begin
         raw_digit = char_code[DIGIT_W-1:0] + LETTER_OFFSET;
      end else begin
         raw_digit = char_code[DIGIT_W-1:0];
      end
   end

   // Check digit range for radix and decode base letter
   always_comb begin
      dec           = '0;
      dec.is_minus  = (char_code == CHAR_MINUS);
      dec.digit     = raw_digit;
      case (radix)
         RK_DEC:  dec.digit_ok = is_num && (raw_digit < DEC_LIMIT);
         RK_BIN:  dec.digit_ok = is_num && (raw_digit < BIN_LIMIT);
         RK_OCT:  dec.digit_ok = is_num && (raw_digit < OCT_LIMIT);
         default: dec.digit_ok = is_num || is_letter;
      endcase
      dec.base_ok   = 1'b1;
      case (char_code)
         CHAR_LC_D: dec.base_kind = RK_DEC;
         CHAR_LC_B: dec.base_kind = RK_BIN;
         CHAR_LC_O: dec.base_kind = RK_OCT;
         CHAR_LC_X: dec.base_kind = RK_HEX;
         default: begin
            dec.base_kind = RK_DEC;
            dec.base_ok   = 1'b0;
         end
      endcase
   end

endmodule

### hdl/rnp_token_core.sv
// Token parse state machine and value accumulator.
module rnp_token_core
   import rnp_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [CHAR_W-1:0]   char_code,
   input  logic                is_last,
   output logic [RESULT_W-1:0] res_value,
   output logic [STATUS_W-1:0] res_status
);

   phase_type              phase_ff, phase_in;
   radix_type              radix_ff, radix_in;
   logic                   minus_ff, minus_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [STATUS_W-1:0]    err_ff, err_in;

   decode_type             dec;
   logic [VALUE_WIDTH-1:0] digit_ext;
   logic [VALUE_WIDTH-1:0] times_ten;
   logic [VALUE_WIDTH-1:0] acc_step;

   rnp_char_decode u_decode (
      .char_code (char_code),
      .radix     (radix_ff),
      .dec       (dec)
   );

   // Shift or scale in one digit; negative decimals count downward
   always_comb begin
      digit_ext = dec.digit_ok ? VALUE_WIDTH'(dec.digit) : '0;
      times_ten = (acc_ff << 3) + (acc_ff << 1);
      case (radix_ff)
         RK_DEC:  acc_step = minus_ff ? times_ten - digit_ext : times_ten + digit_ext;
         RK_BIN:  acc_step = (acc_ff << 1) | digit_ext;
         RK_OCT:  acc_step = (acc_ff << 3) | digit_ext;
         default: acc_step = (acc_ff << 4) | digit_ext;
      endcase
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_START: begin
            if (dec.is_minus) begin
               phase_in = PH_BASE;
            end else if (dec.base_ok) begin
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_BASE: begin
            phase_in = dec.base_ok ? PH_DIGITS : PH_SKIP;
         end
         default: phase_in = phase_ff;
      endcase
   end

   // Datapath updates per phase
   always_comb begin
      radix_in = radix_ff;
      minus_in = minus_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      case (phase_ff)
         PH_START: begin
            if (dec.is_minus) begin
               minus_in = 1'b1;
               if (is_last) begin
                  err_in = STATUS_BAD_BASE;
               end
            end else if (dec.base_ok) begin
               radix_in = dec.base_kind;
            end else begin
               err_in = STATUS_BAD_BASE;
            end
         end
         PH_BASE: begin
            if (dec.base_ok) begin
               radix_in = dec.base_kind;
            end else begin
               err_in = STATUS_BAD_BASE;
            end
         end
         PH_DIGITS: begin
            acc_in = acc_step;
            if (!dec.digit_ok && (err_ff == STATUS_OK)) begin
               err_in = STATUS_BAD_DIGIT;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Result of the token if this character ends it
   always_comb begin
      res_status = err_in;
      res_value  = (err_in == STATUS_BAD_BASE) ? '0 : RESULT_W'(acc_in);
   end

   // Hold state; return to start after the last character
   always_ff @(posedge clock) begin
      if (reset || (step && is_last)) begin
         phase_ff <= PH_START;
         radix_ff <= RK_DEC;
         minus_ff <= 1'b0;
         acc_ff   <= '0;
         err_ff   <= STATUS_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         minus_ff <= minus_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
      end
   end

endmodule

### hdl/ascii_radix_number_parser.sv
// Top level of the ASCII radix number parser: input register, parse core, result register.
//
// Usage: feed one number token as ASCII characters on the req_ stream, one
// character per request, with req_tlast high on its final character. A token
// is an optional '-', a base letter (d, b, o, x) and then digits. For each
// token one result appears on the rsp_ stream: the value in VALUE_WIDTH bits
// (two's complement, zero-extended to 64) and a status (0 ok, 1 unknown base
// letter, 2 invalid digit seen). Characters that are not the last give no result.
// A token's last character is first loaded into the input register; its result
// is then loaded into the result register once that register is free.
// Throughput: one character per cycle unless a last character waits; the digit update
// is one shift or times-ten add/subtract on the accumulator between the two registers.
// When the receiver stalls, the result register holds; the block keeps taking
// non-final characters, and a last character waits in the input register,
// with req_tready low, until the result register frees up.
// Reset clears the parse state, both valid flags and begins a fresh token.
module ascii_radix_number_parser
   import rnp_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   input  logic                  req_tlast,   // is_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [63:0] value, [65:64] status, zero above
);

   logic                  in_valid_ff;
   logic [CHAR_W-1:0]     in_char_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff;
   logic [RESULT_W-1:0]   out_value_ff;
   logic [STATUS_W-1:0]   out_status_ff;

   logic                  out_free;
   logic                  advance;
   logic [RESULT_W-1:0]   res_value;
   logic [STATUS_W-1:0]   res_status;

   // Advance a request unless it ends a token and the result slot is busy
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   rnp_token_core #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_code  (in_char_ff),
      .is_last    (in_last_ff),
      .res_value  (res_value),
      .res_status (res_status)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_value_ff  <= res_value;
         out_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_status_ff, out_value_ff});

endmodule

### tb/ascii_radix_number_parser_tb.sv
// Self-checking stream testbench for the ASCII radix number parser.
module ascii_radix_number_parser_tb;
   import rnp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1200;
   localparam int QUIET_TAIL = 150;
   localparam int LONG_HOLD = 80;
   localparam int LONG_HOLD_AFTER = 40;
   localparam int DRAIN_LIMIT = 2000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 30;

   // One parsed number as it leaves the block
   typedef struct packed {
      logic [RESULT_W-1:0] value;
      logic [STATUS_W-1:0] status;
   } number_result_type;

   // Typed-in expectation that rides along with a character
   typedef struct packed {
      logic                fixed;
      logic [RESULT_W-1:0] value;
      logic [STATUS_W-1:0] status;
   } pinned_result_type;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
      pinned_result_type pin;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata = '0;   // [7:0] char_code
   logic                  req_tlast = 1'b0; // is_last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [63:0] value, [65:64] status, zero above

   // Expectation riding with the request currently on the bus
   pinned_result_type req_pin = '0;

   number_result_type pending_numbers[$];
   directed_row_type  directed[$];

   // Parser state mirrored by the predictor
   phase_type           pr_phase = PH_START;
   radix_type           pr_radix = RK_DEC;
   logic                pr_minus = 1'b0;
   logic [RESULT_W-1:0] pr_acc = '0;
   logic [STATUS_W-1:0] pr_err = STATUS_OK;

   int  chars_sent = 0;
   int  tokens_sent = 0;
   int  numbers_checked = 0;
   int  mismatches = 0;
   int  cycles = 0;
   bit  quiet_tail = 1'b0;
   int  stall_left = 0;
   int  results_taken = 0;
   bit  long_hold_done = 1'b0;

   ascii_radix_number_parser #(
      .VALUE_WIDTH(RESULT_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatches++;
   endtask

   function automatic bit base_letter(input logic [CHAR_W-1:0] c, output radix_type k);
      k = RK_DEC;
      case (c)
         CHAR_LC_D: k = RK_DEC;
         CHAR_LC_B: k = RK_BIN;
         CHAR_LC_O: k = RK_OCT;
         CHAR_LC_X: k = RK_HEX;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Digit value for the radix, or -1 when the byte is not a digit of it
   function automatic int digit_of(input logic [CHAR_W-1:0] c, input radix_type k);
      int d;
      d = -1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = int'(c - CHAR_ZERO);
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
         d = int'(c - CHAR_LC_A) + 10;
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
         d = int'(c - CHAR_UC_A) + 10;
      end
      case (k)
         RK_DEC: if (d >= 10) d = -1;
         RK_BIN: if (d >= 2) d = -1;
         RK_OCT: if (d >= 8) d = -1;
         default: ;
      endcase
      return d;
   endfunction

   // Advance the parser by one character; returns 1 when a number completes
   function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic last,
                                     output number_result_type res);
      radix_type k;
      int        d;
      res = '0;
      case (pr_phase)
         PH_START: begin
            if (c == CHAR_MINUS) begin
               pr_minus = 1'b1;
               pr_phase = PH_BASE;
               if (last) pr_err = STATUS_BAD_BASE;
            end else if (base_letter(c, k)) begin
               pr_radix = k;
               pr_phase = PH_DIGITS;
            end else begin
               pr_err = STATUS_BAD_BASE;
               pr_phase = PH_SKIP;
            end
         end
         PH_BASE: begin
            if (base_letter(c, k)) begin
               pr_radix = k;
               pr_phase = PH_DIGITS;
            end else begin
               pr_err = STATUS_BAD_BASE;
               pr_phase = PH_SKIP;
            end
         end
         PH_DIGITS: begin
            d = digit_of(c, pr_radix);
            // a bad digit still shifts in as zero
            if (d < 0) begin
               d = 0;
               if (pr_err == STATUS_OK) pr_err = STATUS_BAD_DIGIT;
            end
            case (pr_radix)
               RK_DEC: pr_acc = pr_acc * 64'd10 + 64'(d);
               RK_BIN: pr_acc = (pr_acc << 1) | 64'(d);
               RK_OCT: pr_acc = (pr_acc << 3) | 64'(d);
               default: pr_acc = (pr_acc << 4) | 64'(d);
            endcase
         end
         default: ;
      endcase
      if (!last) return 1'b0;
      if (pr_err == STATUS_BAD_BASE) begin
         res.value = '0;
      end else if (pr_radix == RK_DEC && pr_minus) begin
         res.value = -pr_acc;
      end else begin
         res.value = pr_acc;
      end
      res.status = pr_err;
      // start a fresh token
      pr_phase = PH_START;
      pr_radix = RK_DEC;
      pr_minus = 1'b0;
      pr_acc = '0;
      pr_err = STATUS_OK;
      return 1'b1;
   endfunction

   task automatic check_number(input logic [RSP_DATA_W-1:0] data);
      number_result_type want;
      if (pending_numbers.size() == 0) begin
         report_mismatch($sformatf("result with nothing pending: value %h status %0d",
                                   data[RESULT_W-1:0], data[RESULT_W +: STATUS_W]));
         return;
      end
      want = pending_numbers.pop_front();
      numbers_checked++;
      if (data[RESULT_W-1:0] !== want.value) begin
         report_mismatch($sformatf("value %h, want %h", data[RESULT_W-1:0], want.value));
      end
      if (data[RESULT_W +: STATUS_W] !== want.status) begin
         report_mismatch($sformatf("status %0d, want %0d",
                                   data[RESULT_W +: STATUS_W], want.status));
      end
      if (data[RSP_DATA_W-1:RESULT_W+STATUS_W] !== '0) begin
         report_mismatch($sformatf("padding bits %h not zero",
                                   data[RSP_DATA_W-1:RESULT_W+STATUS_W]));
      end
   endtask

   // Check results first, then predict from the accepted request
   always @(posedge clock) begin
      number_result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_number(rsp_tdata);
         if (req_tvalid && req_tready) begin
            if (parse_char(req_tdata, req_tlast, got)) begin
               if (req_pin.fixed) begin
                  got.value = req_pin.value;
                  got.status = req_pin.status;
               end
               pending_numbers.push_back(got);
            end
         end
      end
   end

   // Result sink: short random stalls, one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) results_taken <= results_taken + 1;
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!long_hold_done && results_taken >= LONG_HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            stall_left <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("run stopped: cycle limit of %0d reached, %0d results still pending",
                  CYCLE_LIMIT, pending_numbers.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one character and hold it until the block takes it
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic last,
                            input pinned_result_type pin);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      req_pin <= pin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      if (last) tokens_sent++;
      quiet_tail = (chars_sent >= ITEM_TARGET - QUIET_TAIL);
   endtask

   task automatic add_row(input logic [CHAR_W-1:0] c, input logic last, input logic fixed,
                          input logic [RESULT_W-1:0] value, input logic [STATUS_W-1:0] status);
      directed_row_type row;
      row.code = c;
      row.last = last;
      row.pin.fixed = fixed;
      row.pin.value = value;
      row.pin.status = status;
      directed.push_back(row);
   endtask

   // Mostly well-formed tokens with random digits, some bad bases and raw noise
   task automatic send_random_token();
      logic [CHAR_W-1:0] chars[$];
      int                kind;
      int                ndig;
      int                d;
      radix_type         k;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         if ($urandom_range(0, 2) == 0) chars.push_back(CHAR_MINUS);
         k = radix_type'($urandom_range(0, 3));
         case (k)
            RK_DEC: chars.push_back(CHAR_LC_D);
            RK_BIN: chars.push_back(CHAR_LC_B);
            RK_OCT: chars.push_back(CHAR_LC_O);
            default: chars.push_back(CHAR_LC_X);
         endcase
         // a few long runs to wrap the accumulator
         ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 26) : $urandom_range(0, 8);
         repeat (ndig) begin
            if ($urandom_range(0, 19) == 0) begin
               chars.push_back(8'($urandom_range(0, 255)));
            end else begin
               case (k)
                  RK_DEC: d = $urandom_range(0, 9);
                  RK_BIN: d = $urandom_range(0, 1);
                  RK_OCT: d = $urandom_range(0, 7);
                  default: d = $urandom_range(0, 15);
               endcase
               if (d < 10) begin
                  chars.push_back(CHAR_ZERO + 8'(d));
               end else begin
                  chars.push_back(($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + 8'(d - 10));
               end
            end
         end
      end else if (kind < 90) begin
         if ($urandom_range(0, 1) == 0) chars.push_back(CHAR_MINUS);
         chars.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 4)) chars.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
      end
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, '0);
   endtask

   initial begin : stimulus
      int drain;

      // bare base letter, lone minus, all-ones negative, minus on hex
      add_row(CHAR_LC_D, 1'b1, 1'b1, '0, STATUS_OK);
      add_row(CHAR_MINUS, 1'b1, 1'b1, '0, STATUS_BAD_BASE);
      add_row(CHAR_MINUS, 1'b0, 1'b0, '0, STATUS_OK);
      add_row(CHAR_LC_D, 1'b0, 1'b0, '0, STATUS_OK);
      add_row("1", 1'b1, 1'b1, '1, STATUS_OK);
      add_row(CHAR_MINUS, 1'b0, 1'b0, '0, STATUS_OK);
      add_row(CHAR_LC_X, 1'b0, 1'b0, '0, STATUS_OK);
      add_row("F", 1'b1, 1'b1, 64'hF, STATUS_OK);
      // unknown base letter, then a doubled minus
      add_row("q", 1'b0, 1'b0, '0, STATUS_OK);
      add_row("1", 1'b1, 1'b1, '0, STATUS_BAD_BASE);
      add_row(CHAR_MINUS, 1'b0, 1'b0, '0, STATUS_OK);
      add_row(CHAR_MINUS, 1'b0, 1'b0, '0, STATUS_OK);
      add_row("5", 1'b1, 1'b1, '0, STATUS_BAD_BASE);
      // bad binary digit counts as zero
      add_row(CHAR_LC_B, 1'b0, 1'b0, '0, STATUS_OK);
      add_row("2", 1'b0, 1'b0, '0, STATUS_OK);
      add_row("1", 1'b1, 1'b1, 64'd1, STATUS_BAD_DIGIT);
      // octal and mixed-case hex go through the predictor
      add_row(CHAR_LC_O, 1'b0, 1'b0, '0, STATUS_OK);
      add_row("7", 1'b0, 1'b0, '0, STATUS_OK);
      add_row("7", 1'b1, 1'b0, '0, STATUS_OK);
      add_row(CHAR_LC_X, 1'b0, 1'b0, '0, STATUS_OK);
      add_row("a", 1'b0, 1'b0, '0, STATUS_OK);
      add_row("F", 1'b1, 1'b0, '0, STATUS_OK);
      // byte extremes as base letters, hex letter in decimal
      add_row(8'hFF, 1'b1, 1'b1, '0, STATUS_BAD_BASE);
      add_row(8'h00, 1'b1, 1'b1, '0, STATUS_BAD_BASE);
      add_row(CHAR_LC_D, 1'b0, 1'b0, '0, STATUS_OK);
      add_row("a", 1'b1, 1'b1, '0, STATUS_BAD_DIGIT);

      // hold reset, then release it
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_char(directed[i].code, directed[i].last, directed[i].pin);
      while (chars_sent < ITEM_TARGET) send_random_token();
      req_tvalid <= 1'b0;

      // let the last prediction land, then drain
      @(posedge clock);
      drain = 0;
      while (pending_numbers.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (pending_numbers.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_numbers.size()));
      end

      $display("covered %0d characters in %0d tokens, %0d numbers checked",
               chars_sent, tokens_sent, numbers_checked);
      $display("sink held off %0d cycles once; %0d mismatches", LONG_HOLD, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
